### hw/rtl/rbuf_pkg.sv
// ----------------------------------------------------------------------------
// rbuf_pkg
// shared codes, widths and types of the multichannel sample ring buffer
// ----------------------------------------------------------------------------
package rbuf_pkg;

  // input command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam int NUM_REGS    = 4;   // length registers
  localparam int CFG_W       = 7;   // length register width
  localparam int CMD_W       = 2;
  localparam int CHSEL_W     = 2;   // channel field width
  localparam int SAMPLE_W    = 16;
  localparam int CHAN_W      = 3;   // channel index in a job, up to eight channels
  localparam int POS_W       = 6;   // write position in a job, up to 64 slots
  localparam int LEN_W       = 7;   // window length, up to 64
  localparam int QUEUE_DEPTH = 2;

  // job kinds handed from the front to the back
  typedef enum logic [1:0] {
    OP_WRITE,   // store a sample, then acknowledge
    OP_READ,    // stream the whole window
    OP_ACK,     // single result, ok set
    OP_NAK      // single result, ok clear
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CHAN_W-1:0]   chan;
    logic [POS_W-1:0]    pos;
    logic [LEN_W-1:0]    len;
    logic [SAMPLE_W-1:0] sample;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_len_t;

endpackage

### hw/rtl/rbuf_if.sv
// ----------------------------------------------------------------------------
// rbuf_if
// command and result channel interfaces with valid/ready handshake
// ----------------------------------------------------------------------------
interface rbuf_cmd_if import rbuf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CHSEL_W-1:0]  channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, command, channel, sample, input ready);
  modport sink   (input valid, command, channel, sample, output ready);
endinterface

interface rbuf_res_if import rbuf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [SAMPLE_W-1:0] value;
  logic                last;

  modport source (output valid, ok, value, last, input ready);
  modport sink   (input valid, ok, value, last, output ready);
endinterface

### hw/rtl/rbuf_front.sv
// ----------------------------------------------------------------------------
// rbuf_front
// accepts commands, keeps write positions and full flags, issues jobs
// ----------------------------------------------------------------------------
module rbuf_front import rbuf_pkg::*; #(
  parameter int CHANNELS   = 4,
  parameter int MAX_LENGTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  rbuf_cmd_if.sink in_chan,
  input  cfg_len_t cfg_len,
  output logic     push_valid,
  output job_t     push_job,
  input  logic     push_ready
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  logic [PW-1:0] pos_r [CHANNELS];
  logic          full_r [CHANNELS];

  logic              chan_ok;
  logic [CW-1:0]     ci;
  logic [CFG_W-1:0]  len_raw;
  logic [LEN_W-1:0]  eff_len;
  logic [PW-1:0]     pos;
  logic              wrap;
  logic              take;

  assign in_chan.ready = push_ready;
  assign take          = in_chan.valid && push_ready;

  always_comb begin
    chan_ok = (32'(in_chan.channel) < CHANNELS);
    ci      = CW'(in_chan.channel);
    len_raw = cfg_len[in_chan.channel];

    // length held to the range one to max
    if (len_raw == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(len_raw) > MAX_LENGTH) begin
      eff_len = LEN_W'(MAX_LENGTH);
    end else begin
      eff_len = LEN_W'(len_raw);
    end

    pos = chan_ok ? pos_r[ci] : '0;
    if (32'(pos) >= MAX_LENGTH) begin
      pos = PW'(MAX_LENGTH - 1);
    end
    wrap = (LEN_W'(pos) >= eff_len - LEN_W'(1));

    push_valid      = in_chan.valid;
    push_job.op     = OP_NAK;
    push_job.chan   = CHAN_W'(ci);
    push_job.pos    = POS_W'(pos);
    push_job.len    = eff_len;
    push_job.sample = in_chan.sample;
    if (chan_ok) begin
      unique case (in_chan.command)
        CMD_INSERT: push_job.op = OP_WRITE;
        CMD_READ:   push_job.op = (full_r[ci]) ? OP_READ : OP_NAK;
        CMD_CLEAR:  push_job.op = OP_ACK;
        default:    push_job.op = OP_NAK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c]  <= '0;
        full_r[c] <= 1'b0;
      end
    end else if (take && chan_ok) begin
      if (in_chan.command == CMD_INSERT) begin
        if (wrap) begin
          pos_r[ci]  <= '0;
          full_r[ci] <= 1'b1;
        end else begin
          pos_r[ci] <= PW'(pos + PW'(1));
        end
      end else if (in_chan.command == CMD_CLEAR) begin
        pos_r[ci]  <= '0;
        full_r[ci] <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/rbuf_queue.sv
// ----------------------------------------------------------------------------
// rbuf_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module rbuf_queue import rbuf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  job_t    push_job,
  output logic    push_ready,
  output q_head_t head,
  input  logic    pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (32'(count_r) < QUEUE_DEPTH);
  assign head.valid = (count_r != '0);
  assign head.job   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head.valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(p + PTR_W'(1));
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= CNT_W'(count_r + CNT_W'(1));
      end else if (do_pop && !do_push) begin
        count_r <= CNT_W'(count_r - CNT_W'(1));
      end
    end
  end

endmodule

### hw/rtl/rbuf_back.sv
// ----------------------------------------------------------------------------
// rbuf_back
// sample store, window read sequencer and result register
// ----------------------------------------------------------------------------
module rbuf_back import rbuf_pkg::*; #(
  parameter int CHANNELS   = 4,
  parameter int MAX_LENGTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  q_head_t    head,
  output logic       pop,
  rbuf_res_if.source out_chan
);

  localparam int PW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int DEPTH = CHANNELS << PW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t              state_r;
  logic [PW-1:0]       idx_r;
  logic [LEN_W-1:0]    len_r;
  logic [CHAN_W-1:0]   chan_r;
  logic                out_valid_r;
  logic                out_ok_r;
  logic                out_last_r;
  logic                out_mem_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SAMPLE_W-1:0] store [DEPTH];

  logic          adv;
  logic          head_read;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  function automatic logic [AW-1:0] slot_addr(input logic [CHAN_W-1:0] c,
                                               input logic [PW-1:0] i);
    return AW'((32'(c) << PW) + 32'(i));
  endfunction

  assign adv       = !out_valid_r || out_chan.ready;
  assign pop       = adv && (state_r == S_IDLE);
  assign head_read = head.valid && (head.job.op == OP_READ);
  assign mem_we    = pop && head.valid && (head.job.op == OP_WRITE);
  assign mem_re    = adv && ((state_r == S_READ) || head_read);
  assign waddr     = slot_addr(head.job.chan, PW'(head.job.pos));
  assign raddr     = (state_r == S_READ) ? slot_addr(chan_r, idx_r)
                                         : slot_addr(head.job.chan, '0);

  assign out_chan.valid = out_valid_r;
  assign out_chan.ok    = out_ok_r;
  assign out_chan.last  = out_last_r;
  assign out_chan.value = out_mem_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[waddr] <= head.job.sample;
    end
    if (mem_re) begin
      rd_data_r <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= head.valid;
          out_ok_r    <= (head.job.op != OP_NAK);
          out_mem_r   <= head_read;
          out_last_r  <= !head_read || (head.job.len == LEN_W'(1));
          if (head_read) begin
            len_r  <= head.job.len;
            chan_r <= head.job.chan;
            idx_r  <= PW'(1);
            if (head.job.len != LEN_W'(1)) begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_ok_r    <= 1'b1;
          out_mem_r   <= 1'b1;
          out_last_r  <= (LEN_W'(idx_r) == len_r - LEN_W'(1));
          if (LEN_W'(idx_r) == len_r - LEN_W'(1)) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= PW'(idx_r + PW'(1));
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/multichannel_sample_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// multichannel_sample_ring_buffer_core
// per-channel circular sample windows in one shared store, with apb lengths
// ----------------------------------------------------------------------------
// path: a command taken at the input goes through the job queue, then the
//   store read / result register, before its result leaves the output
// throughput: inserts, clears and failed reads give one result each; a read of
//   a full channel holds the back end for len results, one result per cycle while the output is not stalled
// reset: positions and full flags cleared, lengths back to 64; store contents
//   stay undefined, with no clearing pass
module multichannel_sample_ring_buffer_core import rbuf_pkg::*; #(
  parameter int CHANNELS   = 4,
  parameter int MAX_LENGTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  rbuf_cmd_if.sink    in_chan,
  rbuf_res_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // window length registers, one 32-bit word each
  cfg_len_t len_r;
  logic     cfg_wr;

  // front to queue, queue to back
  logic    push_valid;
  logic    push_ready;
  job_t    push_job;
  q_head_t head;
  logic    pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // register index sits in the word address bits
  assign prdata = 32'(len_r[paddr[3:2]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        len_r[i] <= CFG_W'(64);
      end
    end else if (cfg_wr) begin
      len_r[paddr[3:2]] <= pwdata[CFG_W-1:0];
    end
  end

  // front: classifies the transfer, owns positions and full flags
  rbuf_front #(
    .CHANNELS   (CHANNELS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_len    (len_r),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // decouples the front from window streaming in the back
  rbuf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  // back: store writes, window reads and the result register
  rbuf_back #(
    .CHANNELS   (CHANNELS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // only window streaming produces a result that is not the last one
  a_mid_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last) |-> out_chan.ok)
    else $error("non-final result without ok");

  // a failed command gives a single zero result
  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ok) |-> (out_chan.last && (out_chan.value == '0)))
    else $error("failed command result malformed");

  // the queue never drops a job from the front
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> (push_valid && push_ready))
    else $error("job lost between front and queue");

  // after a final result is taken with the queue empty, nothing new appears
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last && !head.valid)
      |=> !out_chan.valid)
    else $error("result without a job");

endmodule
